// ===== sv/bmm_pkg.sv =====
`timescale 1ns / 1ps

package bmm_pkg;

	// input word op codes
	localparam logic [1:0] OP_ADD_EDGE = 2'd0;
	localparam logic [1:0] OP_RUN      = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	// vertex side codes
	localparam logic [1:0] SIDE_NONE = 2'd0;
	localparam logic [1:0] SIDE_ONE  = 2'd1;
	localparam logic [1:0] SIDE_TWO  = 2'd2;

	localparam int SIZE_W   = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [17:0] {
		ST_CLR   = 18'b000000000000000001,
		ST_IDLE  = 18'b000000000000000010,
		ST_EDGE2 = 18'b000000000000000100,
		ST_INIT  = 18'b000000000000001000,
		ST_CS    = 18'b000000000000010000,
		ST_CS_W  = 18'b000000000000100000,
		ST_QP    = 18'b000000000001000000,
		ST_QP_W  = 18'b000000000010000000,
		ST_BS    = 18'b000000000100000000,
		ST_BC    = 18'b000000001000000000,
		ST_MS    = 18'b000000010000000000,
		ST_MS_W  = 18'b000000100000000000,
		ST_AS    = 18'b000001000000000000,
		ST_PO_W  = 18'b000010000000000000,
		ST_AP_W  = 18'b000100000000000000,
		ST_BK    = 18'b001000000000000000,
		ST_BK_W  = 18'b010000000000000000,
		ST_DONE  = 18'b100000000000000000
	} state_t;

endpackage

// ===== sv/bipartite_max_matching.sv =====
`timescale 1ns / 1ps

// Bipartite check and maximum bipartite matching over a stored graph.
// Input channel (in_valid/in_stall) takes one word per item: op 0 adds the
// undirected edge vertex_a-vertex_b (ignored if an endpoint is outside
// 1..vertex_count, capped at MAX_VERTICES), op 1 runs the check and matching,
// op 2 clears the graph. Output channel (out_valid/out_stall) returns one
// word per op 1 item. Config channel (cfg_valid/cfg_ready) writes vertex_count;
// it is always ready and must only be written while the block is idle.
// Steps: an edge sets the a-b bit on acceptance, then the b-a bit (an
// ignored edge is only taken); a clear is accepted, then zeroes one
// adjacency row a cycle; a run first wipes sides and partners of the
// live vertices, then walks data-dependently through the coloring and
// the augmenting searches, paced by the single adjacency read port and
// one vertex step per cycle of the scan loop.
// in_stall is high whenever the sequencer is busy.
// Reset: after arst_n releases, a clearing pass zeroes every adjacency
// row before the first item is taken.
// A result held by out_stall stays in the output register; edge and clear
// items are still taken, a new run waits at its end until the slot frees.
module bipartite_max_matching
	import bmm_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [COUNT_W-1:0]   vertex_a,
	input  logic [COUNT_W-1:0]   vertex_b,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 bipartite,
	output logic [SIZE_W-1:0]    matching_size,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [COUNT_W-1:0]   vertex_count
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int QW = VW + 2;
	localparam int SW = 2 * VW;

	// storage
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [1:0]              col_mem [MAX_VERTICES];
	logic [VW:0]             par_mem [MAX_VERTICES];  // {valid, partner}
	logic [QW-1:0]           q_mem   [MAX_VERTICES];  // {vertex, side}
	logic [SW-1:0]           stk_mem [MAX_VERTICES+1]; // {vertex, chosen}

	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic [1:0]              col_rd_q;
	logic [VW:0]             par_rd_q;
	logic [QW-1:0]           q_rd_q;
	logic [SW-1:0]           stk_rd_q;

	// control registers
	state_t                  state_q, state_d;
	logic [CW-1:0]           i_q, i_d;
	logic [CW-1:0]           w_q, w_d;
	logic [CW-1:0]           head_q, head_d;
	logic [CW-1:0]           tail_q, tail_d;
	logic [CW-1:0]           d_q, d_d;
	logic [CW-1:0]           k_q, k_d;
	logic [CW-1:0]           total_q, total_d;
	logic [CW-1:0]           n_q, n_d;
	logic [VW-1:0]           u_q, u_d;
	logic [VW-1:0]           eb_q, eb_d;
	logic [VW-1:0]           ea_q, ea_d;
	logic [1:0]              curc_q, curc_d;
	logic [MAX_VERTICES-1:0] seen_q, seen_d;
	logic                    bip_q, bip_d;
	logic [COUNT_W-1:0]      vc_q;
	logic                    out_valid_q;
	logic                    res_bip_q;
	logic [SIZE_W-1:0]       res_size_q;

	// memory strobes
	logic          adj_clr, adj_set, adj_re;
	logic [VW-1:0] adj_wa, adj_wb, adj_ra;
	logic          col_we, col_re;
	logic [VW-1:0] col_wa, col_ra;
	logic [1:0]    col_wd;
	logic          par_we, par_re;
	logic [VW-1:0] par_wa, par_ra;
	logic [VW:0]   par_wd;
	logic          q_we, q_re;
	logic [VW-1:0] q_wa, q_ra;
	logic [QW-1:0] q_wd;
	logic          stk_we, stk_re;
	logic [CW-1:0] stk_wa, stk_ra;
	logic [SW-1:0] stk_wd;

	logic          res_load;
	logic [CW-1:0] n_live;
	logic          a_ok, b_ok;
	logic [VW-1:0] w_idx;
	logic [1:0]    other_side;

	assign n_live = (LW'(vc_q) > LW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_q);
	assign a_ok = (vertex_a != '0) && (LW'(vertex_a) <= LW'(n_live));
	assign b_ok = (vertex_b != '0) && (LW'(vertex_b) <= LW'(n_live));
	assign w_idx = w_q[VW-1:0];
	assign other_side = 2'd3 - curc_q;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign bipartite = res_bip_q;
	assign matching_size = res_size_q;

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		w_d = w_q;
		head_d = head_q;
		tail_d = tail_q;
		d_d = d_q;
		k_d = k_q;
		total_d = total_q;
		n_d = n_q;
		u_d = u_q;
		ea_d = ea_q;
		eb_d = eb_q;
		curc_d = curc_q;
		seen_d = seen_q;
		bip_d = bip_q;
		adj_clr = 1'b0;
		adj_set = 1'b0;
		adj_re = 1'b0;
		adj_wa = '0;
		adj_wb = '0;
		adj_ra = '0;
		col_we = 1'b0;
		col_re = 1'b0;
		col_wa = '0;
		col_ra = '0;
		col_wd = SIDE_NONE;
		par_we = 1'b0;
		par_re = 1'b0;
		par_wa = '0;
		par_ra = '0;
		par_wd = '0;
		q_we = 1'b0;
		q_re = 1'b0;
		q_wa = '0;
		q_ra = '0;
		q_wd = '0;
		stk_we = 1'b0;
		stk_re = 1'b0;
		stk_wa = '0;
		stk_ra = '0;
		stk_wd = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				adj_clr = 1'b1;
				adj_wa = i_q[VW-1:0];
				i_d = i_q + 1'b1;
				if (i_q == CW'(MAX_VERTICES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_ADD_EDGE: begin
							if (a_ok && b_ok) begin
								adj_set = 1'b1;
								adj_wa = VW'(vertex_a - 1'b1);
								adj_wb = VW'(vertex_b - 1'b1);
								ea_d = VW'(vertex_a - 1'b1);
								eb_d = VW'(vertex_b - 1'b1);
								state_d = ST_EDGE2;
							end
						end
						OP_RUN: begin
							n_d = n_live;
							i_d = '0;
							total_d = '0;
							state_d = ST_INIT;
						end
						OP_CLEAR: begin
							i_d = '0;
							state_d = ST_CLR;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EDGE2: begin
				adj_set = 1'b1;
				adj_wa = eb_q;
				adj_wb = ea_q;
				state_d = ST_IDLE;
			end
			ST_INIT: begin
				// wipe sides and partners of the live vertices
				if (i_q == n_q) begin
					i_d = '0;
					state_d = ST_CS;
				end else begin
					col_we = 1'b1;
					col_wa = i_q[VW-1:0];
					col_wd = SIDE_NONE;
					par_we = 1'b1;
					par_wa = i_q[VW-1:0];
					par_wd = '0;
					i_d = i_q + 1'b1;
				end
			end
			ST_CS: begin
				if (i_q == n_q) begin
					i_d = '0;
					bip_d = 1'b1;
					state_d = ST_MS;
				end else begin
					col_re = 1'b1;
					col_ra = i_q[VW-1:0];
					state_d = ST_CS_W;
				end
			end
			ST_CS_W: begin
				if (col_rd_q != SIDE_NONE) begin
					i_d = i_q + 1'b1;
					state_d = ST_CS;
				end else begin
					col_we = 1'b1;
					col_wa = i_q[VW-1:0];
					col_wd = SIDE_ONE;
					q_we = 1'b1;
					q_wa = '0;
					q_wd = {i_q[VW-1:0], SIDE_ONE};
					head_d = '0;
					tail_d = CW'(1);
					state_d = ST_QP;
				end
			end
			ST_QP: begin
				if (head_q == tail_q) begin
					i_d = i_q + 1'b1;
					state_d = ST_CS;
				end else begin
					q_re = 1'b1;
					q_ra = head_q[VW-1:0];
					state_d = ST_QP_W;
				end
			end
			ST_QP_W: begin
				curc_d = q_rd_q[1:0];
				head_d = head_q + 1'b1;
				adj_re = 1'b1;
				adj_ra = q_rd_q[QW-1:2];
				w_d = '0;
				state_d = ST_BS;
			end
			ST_BS: begin
				if (w_q == n_q) begin
					state_d = ST_QP;
				end else if (!adj_rd_q[w_idx]) begin
					w_d = w_q + 1'b1;
				end else begin
					col_re = 1'b1;
					col_ra = w_idx;
					state_d = ST_BC;
				end
			end
			ST_BC: begin
				if (col_rd_q == SIDE_NONE) begin
					col_we = 1'b1;
					col_wa = w_idx;
					col_wd = other_side;
					if (tail_q < CW'(MAX_VERTICES)) begin
						q_we = 1'b1;
						q_wa = tail_q[VW-1:0];
						q_wd = {w_idx, other_side};
						tail_d = tail_q + 1'b1;
					end
					w_d = w_q + 1'b1;
					state_d = ST_BS;
				end else if (col_rd_q == curc_q) begin
					// odd cycle: not bipartite, size stays zero
					bip_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					w_d = w_q + 1'b1;
					state_d = ST_BS;
				end
			end
			ST_MS: begin
				if (i_q == n_q) begin
					state_d = ST_DONE;
				end else begin
					col_re = 1'b1;
					col_ra = i_q[VW-1:0];
					state_d = ST_MS_W;
				end
			end
			ST_MS_W: begin
				if (col_rd_q != SIDE_ONE) begin
					i_d = i_q + 1'b1;
					state_d = ST_MS;
				end else begin
					seen_d = '0;
					d_d = '0;
					u_d = i_q[VW-1:0];
					w_d = '0;
					adj_re = 1'b1;
					adj_ra = i_q[VW-1:0];
					state_d = ST_AS;
				end
			end
			ST_AS: begin
				if (w_q == n_q) begin
					if (d_q == '0) begin
						i_d = i_q + 1'b1;
						state_d = ST_MS;
					end else begin
						d_d = d_q - 1'b1;
						stk_re = 1'b1;
						stk_ra = d_q - 1'b1;
						state_d = ST_PO_W;
					end
				end else if (!adj_rd_q[w_idx] || seen_q[w_idx]) begin
					w_d = w_q + 1'b1;
				end else begin
					seen_d[w_idx] = 1'b1;
					stk_we = 1'b1;
					stk_wa = d_q;
					stk_wd = {u_q, w_idx};
					par_re = 1'b1;
					par_ra = w_idx;
					state_d = ST_AP_W;
				end
			end
			ST_PO_W: begin
				u_d = stk_rd_q[SW-1:VW];
				w_d = CW'(stk_rd_q[VW-1:0]) + 1'b1;
				adj_re = 1'b1;
				adj_ra = stk_rd_q[SW-1:VW];
				state_d = ST_AS;
			end
			ST_AP_W: begin
				if (!par_rd_q[VW]) begin
					k_d = d_q;
					state_d = ST_BK;
				end else if (d_q == CW'(MAX_VERTICES)) begin
					i_d = i_q + 1'b1;
					state_d = ST_MS;
				end else begin
					d_d = d_q + 1'b1;
					u_d = par_rd_q[VW-1:0];
					w_d = '0;
					adj_re = 1'b1;
					adj_ra = par_rd_q[VW-1:0];
					state_d = ST_AS;
				end
			end
			ST_BK: begin
				stk_re = 1'b1;
				stk_ra = k_q;
				state_d = ST_BK_W;
			end
			ST_BK_W: begin
				// flip the path: chosen vertex takes the frame's vertex
				par_we = 1'b1;
				par_wa = stk_rd_q[VW-1:0];
				par_wd = {1'b1, stk_rd_q[SW-1:VW]};
				if (k_q == '0) begin
					total_d = total_q + 1'b1;
					i_d = i_q + 1'b1;
					state_d = ST_MS;
				end else begin
					k_d = k_q - 1'b1;
					state_d = ST_BK;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			i_q <= '0;
			w_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			d_q <= '0;
			k_q <= '0;
			total_q <= '0;
			n_q <= '0;
			bip_q <= 1'b0;
			vc_q <= COUNT_W'(64);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			w_q <= w_d;
			head_q <= head_d;
			tail_q <= tail_d;
			d_q <= d_d;
			k_q <= k_d;
			total_q <= total_d;
			n_q <= n_d;
			bip_q <= bip_d;
			if (cfg_valid) begin
				vc_q <= vertex_count;
			end
			out_valid_q <= res_load | (out_valid_q & out_stall);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		u_q <= u_d;
		ea_q <= ea_d;
		eb_q <= eb_d;
		curc_q <= curc_d;
		seen_q <= seen_d;
		if (res_load) begin
			res_bip_q <= bip_q;
			res_size_q <= (LW'(total_q) > LW'(63)) ? SIZE_W'(63) : SIZE_W'(total_q);
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (adj_clr) begin
			adj_mem[adj_wa] <= '0;
		end else if (adj_set) begin
			adj_mem[adj_wa][adj_wb] <= 1'b1;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		if (col_re) begin
			col_rd_q <= col_mem[col_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		if (par_re) begin
			par_rd_q <= par_mem[par_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		if (q_re) begin
			q_rd_q <= q_mem[q_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Checks graph loading, clearing, two-coloring and maximum matching
// of bipartite_max_matching against a behavioral graph model.
module tb;
	import bmm_pkg::*;

	// No-progress limit in cycles; covers a dense 64-vertex run under stall
	localparam int QUIET_LIMIT = 4000000;
	// Cycles to let an edge or clear finish when no result is due
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 3000;
	localparam int NUM_ITEMS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = OP_ADD_EDGE;
	logic [COUNT_W-1:0] vertex_a = '0;
	logic [COUNT_W-1:0] vertex_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic bipartite;
	logic [SIZE_W-1:0] matching_size;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_W-1:0] vertex_count = 7'd64;

	bipartite_max_matching u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bipartite(bipartite),
		.matching_size(matching_size),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.vertex_count(vertex_count)
	);

	always #5 clk = ~clk;

	// Expected answer of one run word
	typedef struct {
		logic bip;
		logic [SIZE_W-1:0] size;
	} verdict_t;

	verdict_t verdict_q[$];

	// Graph model state
	logic [63:0] adj [64];
	logic [1:0] side [64];
	int unsigned vcount = 64;

	// Idle knobs, in percent per cycle
	int snd_idle = 0;
	int rcv_stall = 0;
	int hold_req = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;

	function automatic int live_n();
		return (vcount > 64) ? 64 : vcount;
	endfunction

	// Breadth-first two-coloring, ascending start vertex; 0 on odd cycle
	function automatic bit color_ok(int n);
		int q[$];
		int cur;
		for (int i = 0; i < 64; i++)
			side[i] = SIDE_NONE;
		for (int s = 0; s < n; s++) begin
			if (side[s] != SIDE_NONE)
				continue;
			side[s] = SIDE_ONE;
			q.delete();
			q = {q, s};
			while (q.size() > 0) begin
				cur = q.pop_front();
				for (int w = 0; w < n; w++) begin
					if (!adj[cur][w])
						continue;
					if (side[w] == SIDE_NONE) begin
						side[w] = (side[cur] == SIDE_ONE) ? SIDE_TWO : SIDE_ONE;
						q = {q, w};
					end else if (side[w] == side[cur]) begin
						return 1'b0;
					end
				end
			end
		end
		return 1'b1;
	endfunction

	// Augmenting-path matching from each side-one vertex, explicit DFS stack
	function automatic int match_count(int n);
		int mate [64];
		logic [63:0] seen;
		int su [65];
		int sv [65];
		int sp [65];
		int d;
		int u;
		int v;
		int total;
		total = 0;
		for (int i = 0; i < 64; i++)
			mate[i] = -1;
		for (int root = 0; root < n; root++) begin
			if (side[root] != SIDE_ONE)
				continue;
			seen = '0;
			d = 0;
			su[0] = root;
			sv[0] = 0;
			while (d >= 0) begin
				u = su[d];
				v = sv[d];
				while (v < n && (!adj[u][v] || seen[v]))
					v++;
				if (v >= n) begin
					d--;
					continue;
				end
				sv[d] = v + 1;
				sp[d] = v;
				seen[v] = 1'b1;
				if (mate[v] < 0) begin
					for (int k = d; k >= 0; k--)
						mate[sp[k]] = su[k];
					total++;
					break;
				end
				d++;
				su[d] = mate[v];
				sv[d] = 0;
			end
		end
		return total;
	endfunction

	// Apply one accepted word to the graph model
	function automatic void graph_apply(logic [1:0] o, logic [6:0] a, logic [6:0] b);
		int n;
		verdict_t vd;
		int sz;
		n = live_n();
		case (o)
			OP_ADD_EDGE: begin
				if (a >= 1 && a <= n && b >= 1 && b <= n) begin
					adj[a-1][b-1] = 1'b1;
					adj[b-1][a-1] = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < 64; i++)
					adj[i] = '0;
			end
			OP_RUN: begin
				vd.bip = color_ok(n);
				sz = vd.bip ? match_count(n) : 0;
				vd.size = (sz > 63) ? 6'd63 : sz[SIZE_W-1:0];
				verdict_q = {verdict_q, vd};
			end
			default: ;
		endcase
	endfunction

	// One input word, with random leading gap
	task automatic send_word(input logic [1:0] o, input logic [6:0] a, input logic [6:0] b);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		vertex_a <= a;
		vertex_b <= b;
		do @(posedge clk); while (in_stall);
		graph_apply(o, a, b);
		n_sent++;
	endtask

	// Quiet the input, drain results, let a trailing edge/clear finish
	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [6:0] v);
		settle();
		cfg_valid <= 1'b1;
		vertex_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vcount = v;
	endtask

	task automatic test_directed();
		send_word(OP_RUN, 0, 0);          // empty graph
		send_word(OP_ADD_EDGE, 1, 2);
		send_word(OP_ADD_EDGE, 64, 63);
		send_word(OP_ADD_EDGE, 2, 1);     // duplicate
		send_word(OP_ADD_EDGE, 0, 5);     // out of range low
		send_word(OP_ADD_EDGE, 65, 1);    // out of range high
		send_word(OP_ADD_EDGE, 127, 127);
		send_word(OP_ADD_EDGE, 5, 0);
		send_word(OP_RUN, 0, 0);
		send_word(OP_ADD_EDGE, 3, 3);     // self-loop
		send_word(OP_RUN, 0, 0);
		send_word(OP_CLEAR, 0, 0);
		send_word(2'd3, 127, 127);        // unused op
		send_word(OP_RUN, 0, 0);
		send_word(OP_ADD_EDGE, 1, 2);     // triangle
		send_word(OP_ADD_EDGE, 2, 3);
		send_word(OP_ADD_EDGE, 3, 1);
		send_word(OP_RUN, 0, 0);
		send_word(OP_CLEAR, 0, 0);
		send_word(OP_ADD_EDGE, 1, 2);     // ring 1-2-3-4 plus a tail
		send_word(OP_ADD_EDGE, 2, 3);
		send_word(OP_ADD_EDGE, 3, 4);
		send_word(OP_ADD_EDGE, 4, 1);
		send_word(OP_ADD_EDGE, 4, 5);
		send_word(OP_RUN, 0, 0);
	endtask

	task automatic test_count_extremes();
		write_count(7'd0);                // no vertices at all
		send_word(OP_ADD_EDGE, 1, 2);
		send_word(OP_RUN, 0, 0);
		write_count(7'd1);
		send_word(OP_ADD_EDGE, 1, 1);
		send_word(OP_ADD_EDGE, 1, 2);
		send_word(OP_RUN, 0, 0);
		write_count(7'd127);              // clamps to 64
		send_word(OP_CLEAR, 0, 0);
		send_word(OP_ADD_EDGE, 64, 1);
		send_word(OP_ADD_EDGE, 65, 2);
		send_word(OP_RUN, 0, 0);
		write_count(7'd8);                // shrink: high edges kept, ignored
		send_word(OP_CLEAR, 0, 0);
		send_word(OP_ADD_EDGE, 7, 8);
		send_word(OP_ADD_EDGE, 1, 2);
		send_word(OP_ADD_EDGE, 4, 4);
		write_count(7'd3);
		send_word(OP_RUN, 0, 0);
		write_count(7'd8);
		send_word(OP_RUN, 0, 0);
	endtask

	// Random graphs: mostly bipartite by construction, some broken, some noise
	task automatic test_random(input int quota, input int n_big);
		int n;
		int n_edges;
		int a;
		int b;
		logic [63:0] col;
		bit loose;
		int stop_at;
		stop_at = n_sent + quota;
		while (n_sent < stop_at) begin
			if (n_big > 0 && $urandom_range(15) == 0) begin
				n = 64;
				n_big--;
			end else begin
				n = $urandom_range(2, 12);
			end
			write_count(n[6:0]);
			send_word(OP_CLEAR, 0, 0);
			col = {$urandom, $urandom};
			loose = ($urandom_range(3) == 0);
			n_edges = (n == 64) ? $urandom_range(20, 120) : $urandom_range(0, 2 * n);
			for (int k = 0; k < n_edges; k++) begin
				if ($urandom_range(11) == 0) begin
					send_word(2'($urandom_range(3)), 7'($urandom_range(127)),
						7'($urandom_range(127)));
					continue;
				end
				a = $urandom_range(1, n);
				b = $urandom_range(1, n);
				for (int t = 0; t < 8 && col[a-1] == col[b-1] && !loose; t++)
					b = $urandom_range(1, n);
				send_word(OP_ADD_EDGE, a[6:0], b[6:0]);
				if ($urandom_range(9) == 0)
					send_word(OP_RUN, 0, 0);
			end
			send_word(OP_RUN, 0, 0);
			if ($urandom_range(4) == 0)
				settle();
		end
	endtask

	// Long receiver hold while runs keep arriving, then a full drain
	task automatic test_backpressure();
		write_count(7'd6);
		send_word(OP_CLEAR, 0, 0);
		hold_req++;
		for (int k = 0; k < 40; k++) begin
			if (k % 4 == 3)
				send_word(OP_RUN, 0, 0);
			else
				send_word(OP_ADD_EDGE, 7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)));
		end
		settle();
	endtask

	// Receiver: random stall, or a long hold when requested
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_stall);
		end
	end

	// Result check against the oldest expected verdict
	always @(posedge clk) begin
		verdict_t vd;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$error("result with no run pending: bipartite=%0d matching_size=%0d",
					bipartite, matching_size);
				errors++;
			end else begin
				vd = verdict_q.pop_front();
				n_checked++;
				if (bipartite !== vd.bip) begin
					$error("bipartite: expected %0d, got %0d", vd.bip, bipartite);
					errors++;
				end
				if (matching_size !== vd.size) begin
					$error("matching_size: expected %0d, got %0d", vd.size, matching_size);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles with no handshake on any channel
	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout with %0d runs outstanding", verdict_q.size());
				$display("bipartite_max_matching: mismatch");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 64; i++)
			adj[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// reset clearing pass
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_directed();
		test_count_extremes();
		snd_idle = 0;  rcv_stall = 0;  test_random(NUM_ITEMS / 4, 2);
		snd_idle = 83; rcv_stall = 0;  test_random(NUM_ITEMS / 4, 0);
		snd_idle = 0;  rcv_stall = 83; test_random(NUM_ITEMS / 4, 1);
		snd_idle = 28; rcv_stall = 28; test_random(NUM_ITEMS / 4, 0);
		snd_idle = 0;  rcv_stall = 0;  test_backpressure();

		settle();
		repeat (200) @(posedge clk);
		$display("sent %0d words, checked %0d run results", n_sent, n_checked);
		$display("vertex counts 0..127, random graphs up to 64 vertices, stalls");
		if (errors == 0 && verdict_q.size() == 0)
			$display("bipartite_max_matching: match");
		else
			$display("bipartite_max_matching: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bmm_pkg.sv
sv/bipartite_max_matching.sv
verif/tb.sv
